// ===== design/psc_pkg.sv =====
package psc_pkg;

  // sizing of the bin tables and the sample store
  localparam int ANGLE_BINS   = 256;
  localparam int DEPTH_BINS   = 1024;
  localparam int VALUE_WIDTH  = 32;

  localparam int ANGLE_AW     = $clog2(ANGLE_BINS);
  localparam int DEPTH_AW     = $clog2(DEPTH_BINS);
  localparam int SAMPLE_DEPTH = ANGLE_BINS * DEPTH_BINS;
  localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);
  localparam int ANGLE_NW     = $clog2(ANGLE_BINS + 1);
  localparam int DEPTH_NW     = $clog2(DEPTH_BINS + 1);
  localparam int SWEEP_MAX    = (ANGLE_BINS > DEPTH_BINS) ? ANGLE_BINS : DEPTH_BINS;
  localparam int SWEEP_W      = $clog2(SWEEP_MAX + 1);

  // fixed field widths of the ports
  localparam int KIND_W       = 2;
  localparam int INDEX_W      = 10;
  localparam int ROW_W        = 8;
  localparam int COL_W        = 10;
  localparam int FIELD_W      = 32;
  localparam int ABIN_W       = 8;
  localparam int DBIN_W       = 10;
  localparam int ACNT_W       = 9;
  localparam int DCNT_W       = 11;

  // register port
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam logic REG_ANGLE_CNT = 1'b0;
  localparam logic REG_DEPTH_CNT = 1'b1;
  localparam logic [ACNT_W-1:0] ANGLE_CNT_RST = ACNT_W'(256);
  localparam logic [DCNT_W-1:0] DEPTH_CNT_RST = DCNT_W'(1024);

  // item kinds as they arrive
  typedef enum logic [KIND_W-1:0] {
    KIND_ANGLE_LOAD  = 2'd0,
    KIND_DEPTH_LOAD  = 2'd1,
    KIND_SAMPLE_LOAD = 2'd2,
    KIND_QUERY       = 2'd3
  } kind_t;

  // operations after classification
  typedef enum logic [2:0] {
    OP_NOP,
    OP_ANGLE_LOAD,
    OP_DEPTH_LOAD,
    OP_SAMPLE_LOAD,
    OP_QUERY
  } op_t;

  // one queued word: val_a is start edge / sample / angle, val_b end edge / distance
  typedef struct packed {
    op_t                    op;
    logic [INDEX_W-1:0]     tix;
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic [VALUE_WIDTH-1:0] val_a;
    logic [VALUE_WIDTH-1:0] val_b;
  } item_t;

  typedef struct packed {
    logic [ACNT_W-1:0] angle_cnt;
    logic [DCNT_W-1:0] depth_cnt;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RANGE,
    S_SWEEP,
    S_SAMPLE,
    S_RESULT
  } state_t;

endpackage

// ===== design/psc_ram.sv =====
module psc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/psc_front.sv =====
module psc_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [psc_pkg::KIND_W-1:0]         in_kind,
  input  logic [psc_pkg::INDEX_W-1:0]        in_table_index,
  input  logic signed [psc_pkg::FIELD_W-1:0] in_start_edge,
  input  logic signed [psc_pkg::FIELD_W-1:0] in_end_edge,
  input  logic [psc_pkg::ROW_W-1:0]          in_sample_row,
  input  logic [psc_pkg::COL_W-1:0]          in_sample_col,
  input  logic signed [psc_pkg::FIELD_W-1:0] in_sample_value,
  input  logic signed [psc_pkg::FIELD_W-1:0] in_query_distance,
  input  logic signed [psc_pkg::FIELD_W-1:0] in_query_angle,
  output psc_pkg::item_t                     head,
  output logic                               head_valid,
  input  logic                               head_pop
);

  psc_pkg::item_t item;
  psc_pkg::item_t q_mem [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  logic           pop;

  // classify the incoming word, out-of-range loads become no-ops
  always_comb begin
    item.tix   = in_table_index;
    item.row   = in_sample_row;
    item.col   = in_sample_col;
    item.val_a = psc_pkg::VALUE_WIDTH'($unsigned(in_start_edge));
    item.val_b = psc_pkg::VALUE_WIDTH'($unsigned(in_end_edge));
    item.op    = psc_pkg::OP_NOP;
    case (psc_pkg::kind_t'(in_kind))
      psc_pkg::KIND_ANGLE_LOAD: begin
        if (32'(in_table_index) < psc_pkg::ANGLE_BINS) item.op = psc_pkg::OP_ANGLE_LOAD;
      end
      psc_pkg::KIND_DEPTH_LOAD: begin
        if (32'(in_table_index) < psc_pkg::DEPTH_BINS) item.op = psc_pkg::OP_DEPTH_LOAD;
      end
      psc_pkg::KIND_SAMPLE_LOAD: begin
        item.val_a = psc_pkg::VALUE_WIDTH'($unsigned(in_sample_value));
        if (32'(in_sample_row) < psc_pkg::ANGLE_BINS &&
            32'(in_sample_col) < psc_pkg::DEPTH_BINS) begin
          item.op = psc_pkg::OP_SAMPLE_LOAD;
        end
      end
      psc_pkg::KIND_QUERY: begin
        item.op    = psc_pkg::OP_QUERY;
        item.val_a = psc_pkg::VALUE_WIDTH'($unsigned(in_query_angle));
        item.val_b = psc_pkg::VALUE_WIDTH'($unsigned(in_query_distance));
      end
      default: item.op = psc_pkg::OP_NOP;
    endcase
  end

  // two-word queue towards the back end
  assign in_ready   = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_mem[rd_ptr_r];
  assign push       = in_valid && in_ready;
  assign pop        = head_pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= item;
    end
  end

endmodule

// ===== design/psc_back.sv =====
module psc_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  psc_pkg::item_t                     head,
  input  logic                               head_valid,
  output logic                               head_pop,
  input  psc_pkg::cfg_t                      cfg,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic signed [psc_pkg::FIELD_W-1:0] out_pixel_value,
  output logic [psc_pkg::ABIN_W-1:0]         out_angle_bin,
  output logic [psc_pkg::DBIN_W-1:0]         out_depth_bin
);

  localparam int VW = psc_pkg::VALUE_WIDTH;

  psc_pkg::state_t state_r, state_nxt;

  logic [psc_pkg::ANGLE_NW-1:0] na;
  logic [psc_pkg::DEPTH_NW-1:0] nd;
  logic [psc_pkg::SWEEP_W-1:0]  sweep_len;
  logic                         sweep_done;
  logic                         issue;
  logic                         res_load;
  logic                         out_free;

  // table and store ports
  logic                           a_we, a_re, d_we, d_re, s_we, s_re;
  logic [psc_pkg::ANGLE_AW-1:0]   a_waddr, a_raddr;
  logic [psc_pkg::DEPTH_AW-1:0]   d_waddr, d_raddr;
  logic [psc_pkg::SAMPLE_AW-1:0]  s_waddr, s_raddr;
  logic [2*VW-1:0]                a_rdata, d_rdata;
  logic [VW-1:0]                  s_rdata;
  logic signed [VW-1:0]           a_start_rd, a_end_rd, d_start_rd, d_end_rd;

  // query working registers
  logic signed [VW-1:0]          ang_r, dist_r;
  logic [psc_pkg::SWEEP_W-1:0]   k_r, kd_r;
  logic                          vd_r;
  logic                          a_lo_r, a_hi_r, a_found_r;
  logic                          d_lo_r, d_hi_r, d_found_r;
  logic [psc_pkg::ANGLE_AW-1:0]  a_bin_r;
  logic [psc_pkg::DEPTH_AW-1:0]  d_bin_r;
  logic                          a_ok, d_ok, both_hit;

  // result register
  logic                               out_valid_r;
  logic                               hit_r;
  logic signed [psc_pkg::FIELD_W-1:0] pix_r;
  logic [psc_pkg::ABIN_W-1:0]         abin_out_r;
  logic [psc_pkg::DBIN_W-1:0]         dbin_out_r;

  // bins in use, saturated at the table depth
  assign na = (32'(cfg.angle_cnt) > psc_pkg::ANGLE_BINS) ?
              psc_pkg::ANGLE_NW'(psc_pkg::ANGLE_BINS) : psc_pkg::ANGLE_NW'(cfg.angle_cnt);
  assign nd = (32'(cfg.depth_cnt) > psc_pkg::DEPTH_BINS) ?
              psc_pkg::DEPTH_NW'(psc_pkg::DEPTH_BINS) : psc_pkg::DEPTH_NW'(cfg.depth_cnt);
  assign sweep_len  = (psc_pkg::SWEEP_W'(na) > psc_pkg::SWEEP_W'(nd)) ?
                      psc_pkg::SWEEP_W'(na) : psc_pkg::SWEEP_W'(nd);
  assign sweep_done = (k_r >= sweep_len);
  assign out_free   = !out_valid_r || out_ready;

  assign a_start_rd = $signed(a_rdata[2*VW-1:VW]);
  assign a_end_rd   = $signed(a_rdata[VW-1:0]);
  assign d_start_rd = $signed(d_rdata[2*VW-1:VW]);
  assign d_end_rd   = $signed(d_rdata[VW-1:0]);

  assign a_ok     = (na != '0) && a_lo_r && a_hi_r && a_found_r;
  assign d_ok     = (nd != '0) && d_lo_r && d_hi_r && d_found_r;
  assign both_hit = a_ok && d_ok;

  // load write ports straight from the queue head
  assign a_waddr = psc_pkg::ANGLE_AW'(head.tix);
  assign d_waddr = psc_pkg::DEPTH_AW'(head.tix);
  assign s_waddr = psc_pkg::SAMPLE_AW'(psc_pkg::SAMPLE_AW'(head.row) *
                   psc_pkg::SAMPLE_AW'(psc_pkg::DEPTH_BINS) + psc_pkg::SAMPLE_AW'(head.col));
  assign s_raddr = psc_pkg::SAMPLE_AW'(psc_pkg::SAMPLE_AW'(a_bin_r) *
                   psc_pkg::SAMPLE_AW'(psc_pkg::DEPTH_BINS) + psc_pkg::SAMPLE_AW'(d_bin_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psc_pkg::S_IDLE: begin
        if (head_valid && head.op == psc_pkg::OP_QUERY) state_nxt = psc_pkg::S_RANGE;
      end
      psc_pkg::S_RANGE:  state_nxt = psc_pkg::S_SWEEP;
      psc_pkg::S_SWEEP: begin
        if (sweep_done && !vd_r) state_nxt = psc_pkg::S_SAMPLE;
      end
      psc_pkg::S_SAMPLE: state_nxt = psc_pkg::S_RESULT;
      psc_pkg::S_RESULT: begin
        if (out_free) state_nxt = psc_pkg::S_IDLE;
      end
      default:  state_nxt = psc_pkg::S_IDLE;
    endcase
  end

  // memory controls and queue pop
  always_comb begin
    head_pop = 1'b0;
    a_we     = 1'b0;
    d_we     = 1'b0;
    s_we     = 1'b0;
    a_re     = 1'b0;
    d_re     = 1'b0;
    s_re     = 1'b0;
    issue    = 1'b0;
    res_load = 1'b0;
    a_raddr  = psc_pkg::ANGLE_AW'(k_r);
    d_raddr  = psc_pkg::DEPTH_AW'(k_r);
    case (state_r)
      psc_pkg::S_IDLE: begin
        if (head_valid) begin
          head_pop = 1'b1;
          case (head.op)
            psc_pkg::OP_ANGLE_LOAD:  a_we = 1'b1;
            psc_pkg::OP_DEPTH_LOAD:  d_we = 1'b1;
            psc_pkg::OP_SAMPLE_LOAD: s_we = 1'b1;
            psc_pkg::OP_QUERY: begin
              // last bin in use first, for the lower end of the span
              a_re    = 1'b1;
              d_re    = 1'b1;
              a_raddr = psc_pkg::ANGLE_AW'(na - psc_pkg::ANGLE_NW'(1));
              d_raddr = psc_pkg::DEPTH_AW'(nd - psc_pkg::DEPTH_NW'(1));
            end
            default: ;
          endcase
        end
      end
      psc_pkg::S_RANGE, psc_pkg::S_SWEEP: begin
        issue = !sweep_done;
        a_re  = issue;
        d_re  = issue;
      end
      psc_pkg::S_SAMPLE: s_re     = both_hit;
      psc_pkg::S_RESULT: res_load = out_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psc_pkg::S_IDLE;
      vd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vd_r    <= issue;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    if (state_r == psc_pkg::S_IDLE && head_valid && head.op == psc_pkg::OP_QUERY) begin
      ang_r     <= $signed(head.val_a);
      dist_r    <= $signed(head.val_b);
      k_r       <= '0;
      a_hi_r    <= 1'b0;
      d_hi_r    <= 1'b0;
      a_found_r <= 1'b0;
      d_found_r <= 1'b0;
      a_bin_r   <= '0;
      d_bin_r   <= '0;
    end
    // lower end of the overall span
    if (state_r == psc_pkg::S_RANGE) begin
      a_lo_r <= (ang_r >= a_end_rd);
      d_lo_r <= (dist_r >= d_end_rd);
    end
    if (issue) begin
      k_r  <= k_r + psc_pkg::SWEEP_W'(1);
      kd_r <= k_r;
    end
    // one entry of each table per cycle, first bin that holds the value wins
    if (vd_r) begin
      if (kd_r < psc_pkg::SWEEP_W'(na)) begin
        if (kd_r == '0) a_hi_r <= (a_start_rd >= ang_r);
        if (!a_found_r && a_start_rd > ang_r && ang_r > a_end_rd) begin
          a_found_r <= 1'b1;
          a_bin_r   <= psc_pkg::ANGLE_AW'(kd_r);
        end
      end
      if (kd_r < psc_pkg::SWEEP_W'(nd)) begin
        if (kd_r == '0) d_hi_r <= (d_start_rd >= dist_r);
        if (!d_found_r && d_start_rd > dist_r && dist_r > d_end_rd) begin
          d_found_r <= 1'b1;
          d_bin_r   <= psc_pkg::DEPTH_AW'(kd_r);
        end
      end
    end
    // result word
    if (res_load) begin
      hit_r      <= both_hit;
      pix_r      <= both_hit ? psc_pkg::FIELD_W'($signed(s_rdata)) : '0;
      abin_out_r <= both_hit ? psc_pkg::ABIN_W'(a_bin_r) : '0;
      dbin_out_r <= both_hit ? psc_pkg::DBIN_W'(d_bin_r) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_pixel_value = pix_r;
  assign out_angle_bin   = abin_out_r;
  assign out_depth_bin   = dbin_out_r;

  // angle edges, start in the upper half
  psc_ram #(
    .WIDTH (2 * VW),
    .DEPTH (psc_pkg::ANGLE_BINS)
  ) u_angle_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata ({head.val_a, head.val_b}),
    .re    (a_re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  // depth edges, start in the upper half
  psc_ram #(
    .WIDTH (2 * VW),
    .DEPTH (psc_pkg::DEPTH_BINS)
  ) u_depth_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata ({head.val_a, head.val_b}),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  // row-by-column sample store
  psc_ram #(
    .WIDTH (VW),
    .DEPTH (psc_pkg::SAMPLE_DEPTH)
  ) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (head.val_a),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

endmodule

// ===== design/polar_bin_scan_convert_core.sv =====
// sequence: a load is written from the queue head as it is popped; a query passes through the
//   range, sweep, sample and result states, the sweep reading one entry of each table per cycle
// overlap: the back end takes no new word until the result of a query is registered; loads
//   go at one per cycle while no query is in progress
// reset: synchronous active-low rst_n clears the queue, sequencer and result valid and
//   sets the bin counts to 256 and 1024; tables and sample store hold no reset
module polar_bin_scan_convert_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [psc_pkg::KIND_W-1:0]         in_kind,
  input  logic [psc_pkg::INDEX_W-1:0]        in_table_index,
  input  logic signed [psc_pkg::FIELD_W-1:0] in_start_edge,
  input  logic signed [psc_pkg::FIELD_W-1:0] in_end_edge,
  input  logic [psc_pkg::ROW_W-1:0]          in_sample_row,
  input  logic [psc_pkg::COL_W-1:0]          in_sample_col,
  input  logic signed [psc_pkg::FIELD_W-1:0] in_sample_value,
  input  logic signed [psc_pkg::FIELD_W-1:0] in_query_distance,
  input  logic signed [psc_pkg::FIELD_W-1:0] in_query_angle,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic signed [psc_pkg::FIELD_W-1:0] out_pixel_value,
  output logic [psc_pkg::ABIN_W-1:0]         out_angle_bin,
  output logic [psc_pkg::DBIN_W-1:0]         out_depth_bin,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [psc_pkg::PADDR_W-1:0]        paddr,
  input  logic [psc_pkg::PDATA_W-1:0]        pwdata,
  output logic [psc_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  psc_pkg::item_t head;
  logic           head_valid;
  logic           head_pop;
  psc_pkg::cfg_t  cfg;

  logic [psc_pkg::ACNT_W-1:0] angle_cnt_r, angle_cnt_nxt;
  logic [psc_pkg::DCNT_W-1:0] depth_cnt_r, depth_cnt_nxt;
  logic                       cfg_wr;
  logic                       reg_sel;

  // register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    angle_cnt_nxt = angle_cnt_r;
    depth_cnt_nxt = depth_cnt_r;
    if (cfg_wr) begin
      case (reg_sel)
        psc_pkg::REG_ANGLE_CNT: angle_cnt_nxt = pwdata[psc_pkg::ACNT_W-1:0];
        psc_pkg::REG_DEPTH_CNT: depth_cnt_nxt = pwdata[psc_pkg::DCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_cnt_r <= psc_pkg::ANGLE_CNT_RST;
      depth_cnt_r <= psc_pkg::DEPTH_CNT_RST;
    end else begin
      angle_cnt_r <= angle_cnt_nxt;
      depth_cnt_r <= depth_cnt_nxt;
    end
  end

  // read-back
  always_comb begin
    case (reg_sel)
      psc_pkg::REG_ANGLE_CNT: prdata = psc_pkg::PDATA_W'(angle_cnt_r);
      psc_pkg::REG_DEPTH_CNT: prdata = psc_pkg::PDATA_W'(depth_cnt_r);
      default:                prdata = '0;
    endcase
  end

  assign cfg.angle_cnt = angle_cnt_r;
  assign cfg.depth_cnt = depth_cnt_r;

  psc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_table_index    (in_table_index),
    .in_start_edge     (in_start_edge),
    .in_end_edge       (in_end_edge),
    .in_sample_row     (in_sample_row),
    .in_sample_col     (in_sample_col),
    .in_sample_value   (in_sample_value),
    .in_query_distance (in_query_distance),
    .in_query_angle    (in_query_angle),
    .head              (head),
    .head_valid        (head_valid),
    .head_pop          (head_pop)
  );

  psc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_valid      (head_valid),
    .head_pop        (head_pop),
    .cfg             (cfg),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_pixel_value (out_pixel_value),
    .out_angle_bin   (out_angle_bin),
    .out_depth_bin   (out_depth_bin)
  );

endmodule

// ===== design/psc_checker.sv =====
module psc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_hit,
  input logic signed [psc_pkg::FIELD_W-1:0] out_pixel_value,
  input logic [psc_pkg::ABIN_W-1:0]         out_angle_bin,
  input logic [psc_pkg::DBIN_W-1:0]         out_depth_bin,
  input logic                               pready
);

  // a waiting result word holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) &&
    $stable(out_pixel_value) && $stable(out_angle_bin) && $stable(out_depth_bin))
    else $error("result word changed while stalled");

  // a miss carries zero value and zero bins
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_pixel_value == '0 && out_angle_bin == '0 &&
    out_depth_bin == '0)
    else $error("miss with non-zero payload");

  // reset empties the result side and opens the input side
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset left the block busy");

  // register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind polar_bin_scan_convert_core psc_checker u_psc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_hit         (out_hit),
  .out_pixel_value (out_pixel_value),
  .out_angle_bin   (out_angle_bin),
  .out_depth_bin   (out_depth_bin),
  .pready          (pready)
);

// ===== dv/polar_bin_scan_convert_core_test.sv =====
module polar_bin_scan_convert_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import psc_pkg::*;

  localparam int unsigned RUN_LIMIT_NS = 10_000_000;
  localparam int DRAIN_CYCLES = 2 * SWEEP_MAX + 64;
  localparam logic [PADDR_W-1:0] ANGLE_CNT_ADDR = PADDR_W'(4 * int'(REG_ANGLE_CNT));
  localparam logic [PADDR_W-1:0] DEPTH_CNT_ADDR = PADDR_W'(4 * int'(REG_DEPTH_CNT));
  localparam int ANGLE_SIDE = 0;
  localparam int DEPTH_SIDE = 1;
  localparam logic signed [FIELD_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [FIELD_W-1:0] VALUE_MIN = 32'sh8000_0000;

  // one input word as the block sees it
  typedef struct {
    kind_t                     kind;
    logic [INDEX_W-1:0]        tix;
    logic signed [FIELD_W-1:0] start_e;
    logic signed [FIELD_W-1:0] end_e;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic signed [FIELD_W-1:0] sval;
    logic signed [FIELD_W-1:0] distance;
    logic signed [FIELD_W-1:0] ang;
  } scan_word_t;

  // one output pixel word
  typedef struct {
    logic                      hit;
    logic signed [FIELD_W-1:0] value;
    logic [ABIN_W-1:0]         abin;
    logic [DBIN_W-1:0]         dbin;
  } pixel_t;

  // shadow of the bin tables and sample store, plus the pixels still owed
  class scan_scoreboard;
    bit signed [FIELD_W-1:0]   upper [2][DEPTH_BINS];
    bit signed [FIELD_W-1:0]   lower [2][DEPTH_BINS];
    bit                        filled [2][DEPTH_BINS];
    logic signed [FIELD_W-1:0] samples [int];
    logic [ACNT_W-1:0]         angle_cnt = ANGLE_CNT_RST;
    logic [DCNT_W-1:0]         depth_cnt = DEPTH_CNT_RST;
    pixel_t                    pending_pixels [$];
    int                        errors;
    int                        queries;
    int                        hits;
    int                        loads;

    function int bins_in_use(int side);
      if (side == ANGLE_SIDE) begin
        return (angle_cnt > ANGLE_BINS) ? ANGLE_BINS : int'(angle_cnt);
      end
      return (depth_cnt > DEPTH_BINS) ? DEPTH_BINS : int'(depth_cnt);
    endfunction

    function void set_count(logic [PADDR_W-1:0] addr, int unsigned value);
      if (addr == ANGLE_CNT_ADDR) begin
        angle_cnt = ACNT_W'(value);
      end else if (addr == DEPTH_CNT_ADDR) begin
        depth_cnt = DCNT_W'(value);
      end
    endfunction

    // overall span check, then first bin with start > v > end
    function bit find_bin(int side, logic signed [FIELD_W-1:0] v, output int bin);
      int n;
      int k;
      n = bins_in_use(side);
      bin = 0;
      if (n == 0) return 1'b0;
      if (!(upper[side][0] >= v && v >= lower[side][n-1])) return 1'b0;
      for (k = 0; k < n; k++) begin
        if (upper[side][k] > v && v > lower[side][k]) begin
          bin = k;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function bit sample_known(int abin, int dbin);
      return samples.exists(abin * DEPTH_BINS + dbin);
    endfunction

    function pixel_t lookup_pixel(logic signed [FIELD_W-1:0] ang,
                                  logic signed [FIELD_W-1:0] distance);
      pixel_t p;
      int     abin;
      int     dbin;
      bit     ahit;
      bit     dhit;
      ahit = find_bin(ANGLE_SIDE, ang, abin);
      dhit = find_bin(DEPTH_SIDE, distance, dbin);
      p.hit = ahit && dhit;
      p.value = '0;
      p.abin = '0;
      p.dbin = '0;
      if (p.hit) begin
        p.value = sample_known(abin, dbin) ? samples[abin * DEPTH_BINS + dbin] : '0;
        p.abin = ABIN_W'(abin);
        p.dbin = DBIN_W'(dbin);
      end
      return p;
    endfunction

    // accepted input word: update shadow state or owe a pixel
    function void note_word(scan_word_t w);
      pixel_t p;
      case (w.kind)
        KIND_ANGLE_LOAD: begin
          loads++;
          if (w.tix < ANGLE_BINS) begin
            upper[ANGLE_SIDE][w.tix] = w.start_e;
            lower[ANGLE_SIDE][w.tix] = w.end_e;
            filled[ANGLE_SIDE][w.tix] = 1'b1;
          end
        end
        KIND_DEPTH_LOAD: begin
          loads++;
          if (w.tix < DEPTH_BINS) begin
            upper[DEPTH_SIDE][w.tix] = w.start_e;
            lower[DEPTH_SIDE][w.tix] = w.end_e;
            filled[DEPTH_SIDE][w.tix] = 1'b1;
          end
        end
        KIND_SAMPLE_LOAD: begin
          loads++;
          samples[int'(w.row) * DEPTH_BINS + int'(w.col)] = w.sval;
        end
        default: begin
          queries++;
          p = lookup_pixel(w.ang, w.distance);
          if (p.hit) hits++;
          pending_pixels.push_back(p);
        end
      endcase
    endfunction

    // accepted output word against the oldest owed pixel
    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $error("pixel word with no query waiting: hit %0b value %0d", got.hit, got.value);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.hit !== want.hit) begin
        errors++;
        $error("hit: expected %0b, got %0b", want.hit, got.hit);
      end
      if (got.value !== want.value) begin
        errors++;
        $error("pixel_value: expected %0d, got %0d", want.value, got.value);
      end
      if (got.abin !== want.abin) begin
        errors++;
        $error("angle_bin: expected %0d, got %0d", want.abin, got.abin);
      end
      if (got.dbin !== want.dbin) begin
        errors++;
        $error("depth_bin: expected %0d, got %0d", want.dbin, got.dbin);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  wire                       in_ready;
  logic [KIND_W-1:0]         in_kind = '0;
  logic [INDEX_W-1:0]        in_table_index = '0;
  logic signed [FIELD_W-1:0] in_start_edge = '0;
  logic signed [FIELD_W-1:0] in_end_edge = '0;
  logic [ROW_W-1:0]          in_sample_row = '0;
  logic [COL_W-1:0]          in_sample_col = '0;
  logic signed [FIELD_W-1:0] in_sample_value = '0;
  logic signed [FIELD_W-1:0] in_query_distance = '0;
  logic signed [FIELD_W-1:0] in_query_angle = '0;
  wire                       out_valid;
  logic                      out_ready = 1'b0;
  wire                       out_hit;
  wire signed [FIELD_W-1:0]  out_pixel_value;
  wire [ABIN_W-1:0]          out_angle_bin;
  wire [DBIN_W-1:0]          out_depth_bin;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PADDR_W-1:0]        paddr = '0;
  logic [PDATA_W-1:0]        pwdata = '0;
  wire [PDATA_W-1:0]         prdata;
  wire                       pready;

  scan_scoreboard sb = new();
  bit             in_calm;
  bit             out_calm;
  int             settings;

  polar_bin_scan_convert_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_table_index    (in_table_index),
    .in_start_edge     (in_start_edge),
    .in_end_edge       (in_end_edge),
    .in_sample_row     (in_sample_row),
    .in_sample_col     (in_sample_col),
    .in_sample_value   (in_sample_value),
    .in_query_distance (in_query_distance),
    .in_query_angle    (in_query_angle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_pixel_value   (out_pixel_value),
    .out_angle_bin     (out_angle_bin),
    .out_depth_bin     (out_depth_bin),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hard stop
  initial begin
    #RUN_LIMIT_NS;
    $display("run timed out waiting on the block");
    $display("FAILURE");
    $finish;
  end

  function automatic logic signed [FIELD_W-1:0] clamp_value(longint v);
    if (v > longint'(VALUE_MAX)) return VALUE_MAX;
    if (v < longint'(VALUE_MIN)) return VALUE_MIN;
    return FIELD_W'(v);
  endfunction

  function automatic logic signed [FIELD_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2: return '0;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // every field but the kind random, so unused fields toggle too
  function automatic scan_word_t random_word();
    scan_word_t w;
    w.kind = KIND_QUERY;
    w.tix = INDEX_W'($urandom);
    w.start_e = FIELD_W'($urandom);
    w.end_e = FIELD_W'($urandom);
    w.row = ROW_W'($urandom);
    w.col = COL_W'($urandom);
    w.sval = FIELD_W'($urandom);
    w.distance = FIELD_W'($urandom);
    w.ang = FIELD_W'($urandom);
    return w;
  endfunction

  // query coordinate: mostly inside a bin, else on an edge or anywhere
  function automatic logic signed [FIELD_W-1:0] pick_value(int side, int n);
    int     k;
    int     m;
    longint hi;
    longint lo;
    if (n == 0) return random_value();
    k = $urandom_range(0, n - 1);
    hi = sb.upper[side][k];
    lo = sb.lower[side][k];
    m = $urandom_range(0, 9);
    if (m <= 6 && hi - lo >= 2) begin
      return FIELD_W'(lo + 1 + longint'($urandom_range(0, 32'(hi - lo - 2))));
    end
    if (m <= 7) begin
      case ($urandom_range(0, 3))
        0: return FIELD_W'(hi);
        1: return FIELD_W'(lo);
        2: return sb.upper[side][0];
        default: return sb.lower[side][n-1];
      endcase
    end
    return random_value();
  endfunction

  // present one word and hold it until taken
  task automatic send_word(input scan_word_t w);
    int gap;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_kind <= w.kind;
    in_table_index <= w.tix;
    in_start_edge <= w.start_e;
    in_end_edge <= w.end_e;
    in_sample_row <= w.row;
    in_sample_col <= w.col;
    in_sample_value <= w.sval;
    in_query_distance <= w.distance;
    in_query_angle <= w.ang;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic send_bin(input int side, input int k,
                          input logic signed [FIELD_W-1:0] s,
                          input logic signed [FIELD_W-1:0] e);
    scan_word_t w;
    w = random_word();
    w.kind = (side == DEPTH_SIDE) ? KIND_DEPTH_LOAD : KIND_ANGLE_LOAD;
    w.tix = INDEX_W'(k);
    w.start_e = s;
    w.end_e = e;
    send_word(w);
  endtask

  task automatic send_sample(input int row, input int col,
                             input logic signed [FIELD_W-1:0] value);
    scan_word_t w;
    w = random_word();
    w.kind = KIND_SAMPLE_LOAD;
    w.row = ROW_W'(row);
    w.col = COL_W'(col);
    w.sval = value;
    send_word(w);
  endtask

  // a hit on a never-loaded cell is not allowed, so load it first
  task automatic send_query(input logic signed [FIELD_W-1:0] ang,
                            input logic signed [FIELD_W-1:0] distance);
    scan_word_t w;
    pixel_t     p;
    p = sb.lookup_pixel(ang, distance);
    if (p.hit && !sb.sample_known(p.abin, p.dbin)) begin
      send_sample(p.abin, p.dbin, random_value());
    end
    w = random_word();
    w.kind = KIND_QUERY;
    w.ang = ang;
    w.distance = distance;
    send_word(w);
  endtask

  // register write, then read back the masked value
  task automatic write_count(input logic [PADDR_W-1:0] addr, input int unsigned value);
    logic [PDATA_W-1:0] want;
    want = (addr == DEPTH_CNT_ADDR) ? PDATA_W'(DCNT_W'(value)) : PDATA_W'(ACNT_W'(value));
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {16'($urandom), 16'(value)};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_count(addr, value);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      sb.errors++;
      $error("prdata: expected %0d, got %0d", want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    settings++;
  endtask

  // drop valid, wait for owed pixels, then let queued loads drain
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // fill bins 0..n-1 of one table in one of four layouts
  task automatic lay_out(input int side, input int n, input bit fresh);
    int     style;
    int     k;
    longint top;
    longint width;
    longint span;
    longint s;
    longint e;
    style = $urandom_range(0, 3);
    top = 0;
    width = 1;
    if (n > 0) begin
      if (style == 2) begin
        // spread over the whole number range
        width = 64'd4294967296 / n;
        top = longint'(VALUE_MAX);
      end else begin
        width = ($urandom_range(0, 1) == 0) ? longint'($urandom_range(1, 64))
                : longint'($urandom_range(1, 32'hFFFF_FFFF / (n + 1)));
        span = 64'hFFFF_FFFF - longint'(n) * width;
        top = longint'(VALUE_MIN) + longint'(n) * width
              + longint'($urandom_range(0, 32'(span)));
      end
    end
    for (k = 0; k < n; k++) begin
      if (!fresh && sb.filled[side][k]) continue;
      s = top - longint'(k) * width;
      e = s - width;
      if (style == 1) begin
        // small gaps and overlaps between neighbours
        s = s + longint'($urandom_range(0, 4)) - 2;
        e = e + longint'($urandom_range(0, 4)) - 2;
      end
      if (style == 3) begin
        s = longint'(random_value());
        e = longint'(random_value());
      end
      send_bin(side, k, clamp_value(s), clamp_value(e));
    end
  endtask

  // one random word: query, sample load or bin reload
  task automatic random_step(input int na, input int nd, output bit counted);
    int pick;
    int side;
    int n;
    int k;
    counted = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_query(pick_value(ANGLE_SIDE, na), pick_value(DEPTH_SIDE, nd));
    end else if (pick < 75) begin
      send_sample((na > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, na - 1)
                  : $urandom_range(0, ANGLE_BINS - 1),
                  (nd > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, nd - 1)
                  : $urandom_range(0, DEPTH_BINS - 1),
                  random_value());
    end else begin
      side = $urandom_range(0, 1);
      n = (side == DEPTH_SIDE) ? nd : na;
      if (n > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, n - 1);
        if ($urandom_range(0, 2) == 0) begin
          send_bin(side, k, random_value(), random_value());
        end else begin
          send_bin(side, k,
                   clamp_value(longint'(sb.upper[side][k]) + longint'($urandom_range(0, 6)) - 3),
                   clamp_value(longint'(sb.lower[side][k]) + longint'($urandom_range(0, 6)) - 3));
        end
      end else if (side == ANGLE_SIDE) begin
        // beyond the angle table: dropped by the block
        send_bin(side, $urandom_range(ANGLE_BINS, (1 << INDEX_W) - 1),
                 random_value(), random_value());
        counted = 1'b0;
      end else begin
        send_bin(side, $urandom_range(0, DEPTH_BINS - 1), random_value(), random_value());
      end
    end
  endtask

  task automatic run_phase(input int unsigned acnt, input int unsigned dcnt,
                           input bit fresh, input int words);
    int na;
    int nd;
    int done;
    bit counted;
    settle();
    write_count(ANGLE_CNT_ADDR, acnt);
    write_count(DEPTH_CNT_ADDR, dcnt);
    na = sb.bins_in_use(ANGLE_SIDE);
    nd = sb.bins_in_use(DEPTH_SIDE);
    lay_out(ANGLE_SIDE, na, fresh);
    lay_out(DEPTH_SIDE, nd, fresh);
    done = 0;
    while (done < words) begin
      random_step(na, nd, counted);
      if (counted) done++;
    end
  endtask

  // hand-picked edges: extreme edges, exact boundaries, bin 0, dropped load
  task automatic run_directed();
    settle();
    write_count(ANGLE_CNT_ADDR, 2);
    write_count(DEPTH_CNT_ADDR, 3);
    send_bin(ANGLE_SIDE, 0, VALUE_MAX, 32'sd0);
    send_bin(ANGLE_SIDE, 1, 32'sd0, VALUE_MIN);
    send_bin(ANGLE_SIDE, 700, 32'sd5, -32'sd5);
    send_bin(DEPTH_SIDE, 0, VALUE_MAX, 32'sd1000);
    send_bin(DEPTH_SIDE, 1, 32'sd1000, -32'sd1000);
    send_bin(DEPTH_SIDE, 2, -32'sd1000, VALUE_MIN);
    send_sample(0, 0, VALUE_MAX);
    send_sample(1, 2, VALUE_MIN);
    send_sample(0, 1, 32'sh1234_5678);
    send_sample(ANGLE_BINS - 1, DEPTH_BINS - 1, -32'sd1);
    send_query(32'sd100, 32'sd2000);
    send_query(-32'sd100, -32'sd2000);
    send_query(32'sd1, 32'sd0);
    send_query(32'sd0, 32'sd5);
    send_query(VALUE_MAX, 32'sd0);
    send_query(VALUE_MIN, 32'sd0);
    send_query(32'sd1, 32'sd1000);
    send_query(32'sd1, VALUE_MIN);
    send_query(VALUE_MAX - 32'sd1, VALUE_MIN + 32'sd1);
  endtask

  // pixel sink with random back-pressure
  initial begin : pixel_sink
    pixel_t got;
    int     stall;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.hit = out_hit;
      got.value = out_pixel_value;
      got.abin = out_angle_bin;
      got.dbin = out_depth_bin;
      sb.check_pixel(got);
    end
  end

  // reset, directed words, then phases from zero and one bins up to a saturated angle count
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_phase(1, 1, 1'b1, 30);
    run_phase(0, 7, 1'b1, 16);
    run_phase(12, 0, 1'b1, 16);
    run_phase(9, 40, 1'b1, 50);
    run_phase(33, 17, 1'b1, 50);
    run_phase(300, 6, 1'b1, 12);
    run_phase(511, 3, 1'b0, 16);
    settle();
    $display("covered %0d pixel queries (%0d hits, %0d misses) and %0d bin and sample loads",
             sb.queries, sb.hits, sb.queries - sb.hits, sb.loads);
    $display("over %0d bin count writes, from zero and one bins up to a saturated angle table",
             settings);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
